FILE: design/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg: shared types and constants of the stroke direction tokenizer
// Command codes, direction codes, the sector slope constant and the control
// word that travels down the pipeline.
// ----------------------------------------------------------------------------
package sdt_pkg;

    typedef enum logic [1:0] {
        OP_ADD_POINT  = 2'd0,
        OP_CLEAR      = 2'd1,
        OP_READ_TOKEN = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        DIR_R  = 3'd0,
        DIR_UR = 3'd1,
        DIR_U  = 3'd2,
        DIR_UL = 3'd3,
        DIR_L  = 3'd4,
        DIR_DL = 3'd5,
        DIR_D  = 3'd6,
        DIR_DR = 3'd7
    } t_dir;

    // tan(22.5 deg) in Q16
    localparam int             TAN_W          = 15;
    localparam logic [TAN_W-1:0] TAN_SECTOR_Q16 = 15'd27146;
    localparam int             Q_SHIFT        = 16;

    localparam int             MIN_SEG_W      = 12;
    localparam int             MIN_SQ_W       = 2 * MIN_SEG_W;
    localparam logic [MIN_SEG_W-1:0] MIN_SEG_RESET = 12'd24;

    localparam int             TOKEN_W        = 3;
    localparam int             READ_W         = 8;
    localparam int             INDEX_W        = 8;
    localparam int             COUNT_OUT_W    = 7;
    localparam logic [READ_W-1:0] NO_TOKEN    = 8'hFF;

    typedef struct packed {
        t_op  op;
        logic moved;      // point is far enough: anchor moved, direction taken
        logic dx_pos;     // dx > 0
        logic dy_neg;     // dy < 0
        logic zero_disp;  // dx == 0 and dy == 0
    } t_ctl;

endpackage

FILE: design/sdt_cmd_if.sv
// ----------------------------------------------------------------------------
// sdt_cmd_if: command channel
// One beat carries an opcode, a pointer point and a token read index.
// ----------------------------------------------------------------------------
interface sdt_cmd_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic [7:0]                    read_index;

    modport source (output valid, opcode, point_x, point_y, read_index, input ready);
    modport sink   (input valid, opcode, point_x, point_y, read_index, output ready);
endinterface

FILE: design/sdt_res_if.sv
// ----------------------------------------------------------------------------
// sdt_res_if: result channel
// One beat per command: append flag, direction, token count and read value.
// ----------------------------------------------------------------------------
interface sdt_res_if;
    logic       valid;
    logic       ready;
    logic       appended;
    logic [2:0] new_direction;
    logic [6:0] token_count;
    logic [7:0] read_value;

    modport source (output valid, appended, new_direction, token_count, read_value,
                    input ready);
    modport sink   (input valid, appended, new_direction, token_count, read_value,
                    output ready);
endinterface

FILE: design/sdt_cfg_if.sv
// ----------------------------------------------------------------------------
// sdt_cfg_if: configuration write channel
// One beat writes the minimum segment length.
// ----------------------------------------------------------------------------
interface sdt_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] min_len;

    modport source (output valid, min_len, input ready);
    modport sink   (input valid, min_len, output ready);
endinterface

FILE: design/sdt_ram.sv
// ----------------------------------------------------------------------------
// sdt_ram: generic single-clock RAM
// One write port, one read port with registered read data (old data on a
// same-address write).
// ----------------------------------------------------------------------------
module sdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/sdt_seg.sv
// ----------------------------------------------------------------------------
// sdt_seg: anchor and segment length stage
// Holds the anchor, takes the displacement of each point and decides whether
// it is long enough to yield a direction.
// ----------------------------------------------------------------------------
module sdt_seg #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  sdt_pkg::t_op                  i_op,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic [sdt_pkg::MIN_SQ_W-1:0]  i_min_sq,
    output logic [COORD_WIDTH-1:0]        o_abs_x,
    output logic [COORD_WIDTH-1:0]        o_abs_y,
    output sdt_pkg::t_ctl                 o_ctl
);
    localparam int DW   = COORD_WIDTH + 1;
    localparam int SQW  = 2 * COORD_WIDTH + 1;
    localparam int CMPW = (SQW > sdt_pkg::MIN_SQ_W) ? SQW : sdt_pkg::MIN_SQ_W;

    logic signed [COORD_WIDTH-1:0] r_anchor_x;
    logic signed [COORD_WIDTH-1:0] r_anchor_y;
    logic                          r_anchor_valid;
    logic [COORD_WIDTH-1:0]        r_abs_x;
    logic [COORD_WIDTH-1:0]        r_abs_y;
    sdt_pkg::t_ctl                 r_ctl;

    logic signed [DW-1:0]     dx;
    logic signed [DW-1:0]     dy;
    logic [DW-1:0]            ax_full;
    logic [DW-1:0]            ay_full;
    logic [COORD_WIDTH-1:0]   ax;
    logic [COORD_WIDTH-1:0]   ay;
    logic [2*COORD_WIDTH-1:0] sq_x;
    logic [2*COORD_WIDTH-1:0] sq_y;
    logic [CMPW-1:0]          dist_sq;
    logic                     moved;
    sdt_pkg::t_ctl            ctl;

    always_comb begin
        dx      = DW'(i_point_x) - DW'(r_anchor_x);
        dy      = DW'(i_point_y) - DW'(r_anchor_y);
        ax_full = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay_full = dy[DW-1] ? DW'(-dy) : DW'(dy);
        ax      = ax_full[COORD_WIDTH-1:0];
        ay      = ay_full[COORD_WIDTH-1:0];
        sq_x    = ax * ax;
        sq_y    = ay * ay;
        dist_sq = CMPW'(sq_x) + CMPW'(sq_y);
        moved   = (i_op == sdt_pkg::OP_ADD_POINT) && r_anchor_valid &&
                  (dist_sq >= CMPW'(i_min_sq));

        ctl.op        = i_op;
        ctl.moved     = moved;
        ctl.dx_pos    = !dx[DW-1] && (dx != '0);
        ctl.dy_neg    = dy[DW-1];
        ctl.zero_disp = (ax == '0) && (ay == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_valid <= 1'b0;
        end else if (i_load) begin
            unique case (i_op)
                sdt_pkg::OP_ADD_POINT:  r_anchor_valid <= 1'b1;
                sdt_pkg::OP_CLEAR:      r_anchor_valid <= 1'b0;
                default:                r_anchor_valid <= r_anchor_valid;
            endcase
        end
    end

    // take the point as the new anchor when it starts a stroke or moves far enough
    always_ff @(posedge i_clk) begin
        if (i_load && (i_op == sdt_pkg::OP_ADD_POINT) && (!r_anchor_valid || moved)) begin
            r_anchor_x <= i_point_x;
            r_anchor_y <= i_point_y;
        end
        if (i_load) begin
            r_abs_x <= ax;
            r_abs_y <= ay;
            r_ctl   <= ctl;
        end
    end

    assign o_abs_x = r_abs_x;
    assign o_abs_y = r_abs_y;
    assign o_ctl   = r_ctl;
endmodule

FILE: design/sdt_dir.sv
// ----------------------------------------------------------------------------
// sdt_dir: direction quantizer stage
// Registers both slope products, then sorts the displacement into one of
// eight sectors.
// ----------------------------------------------------------------------------
module sdt_dir #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic [COORD_WIDTH-1:0] i_abs_x,
    input  logic [COORD_WIDTH-1:0] i_abs_y,
    input  sdt_pkg::t_ctl          i_ctl,
    output sdt_pkg::t_ctl          o_ctl,
    output sdt_pkg::t_dir          o_dir
);
    localparam int PW = COORD_WIDTH + sdt_pkg::TAN_W;
    localparam int QW = COORD_WIDTH + sdt_pkg::Q_SHIFT;

    logic [COORD_WIDTH-1:0] r_abs_x;
    logic [COORD_WIDTH-1:0] r_abs_y;
    logic [PW-1:0]          r_tan_x;
    logic [PW-1:0]          r_tan_y;
    sdt_pkg::t_ctl          r_ctl;

    logic [QW-1:0] ax_sh;
    logic [QW-1:0] ay_sh;
    logic          horiz;
    logic          vert;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_abs_x <= i_abs_x;
            r_abs_y <= i_abs_y;
            r_tan_x <= PW'(i_abs_x) * PW'(sdt_pkg::TAN_SECTOR_Q16);
            r_tan_y <= PW'(i_abs_y) * PW'(sdt_pkg::TAN_SECTOR_Q16);
            r_ctl   <= i_ctl;
        end
    end

    always_comb begin
        ax_sh = {r_abs_x, {sdt_pkg::Q_SHIFT{1'b0}}};
        ay_sh = {r_abs_y, {sdt_pkg::Q_SHIFT{1'b0}}};
        horiz = ay_sh < QW'(r_tan_x);
        vert  = ax_sh < QW'(r_tan_y);

        // ties between sectors fall through to the diagonal
        priority if (r_ctl.zero_disp) begin
            o_dir = sdt_pkg::DIR_R;
        end else if (horiz) begin
            o_dir = r_ctl.dx_pos ? sdt_pkg::DIR_R : sdt_pkg::DIR_L;
        end else if (vert) begin
            o_dir = r_ctl.dy_neg ? sdt_pkg::DIR_U : sdt_pkg::DIR_D;
        end else if (r_ctl.dx_pos) begin
            o_dir = r_ctl.dy_neg ? sdt_pkg::DIR_UR : sdt_pkg::DIR_DR;
        end else begin
            o_dir = r_ctl.dy_neg ? sdt_pkg::DIR_UL : sdt_pkg::DIR_DL;
        end
    end

    assign o_ctl = r_ctl;
endmodule

FILE: design/stroke_direction_tokenizer.sv
// ----------------------------------------------------------------------------
// stroke_direction_tokenizer: eight-direction pointer gesture tokenizer
// Turns a stream of pointer points into a string of direction tokens held in
// a token RAM, with clear and token read commands.
// ----------------------------------------------------------------------------
// The block takes one command beat per clock unless the result side stalls
// and returns exactly one result beat per command, in order, from the output
// register. Throughput is one command per cycle with no interlock; the
// tightest path is the anchor loop of the first stage, where the displacement
// from the anchor is squared and compared with the minimum segment length
// squared in the same cycle, because the next point must see the anchor this
// one leaves. Stage two registers the two slope products against
// tan(22.5 deg); stage three sorts the direction, checks it against the last
// token, writes the token RAM and resolves reads. Token reads issue to the
// RAM in stage two; a write from stage three to the same entry in the same
// cycle is forwarded. Each stage holds its beat until the next one frees up,
// so bubbles close while the output register waits. Neither the command nor
// the configuration side is ready while reset is held. The token RAM needs no
// clearing after reset: entries at or above the token count are never
// returned. The minimum segment length may be written only while no command
// is in flight.
// ----------------------------------------------------------------------------
module stroke_direction_tokenizer #(
    parameter int MAX_TOKENS_HELD = 64,
    parameter int COORD_WIDTH     = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sdt_cmd_if.sink   i_cmd,
    sdt_cfg_if.sink   i_cfg,
    sdt_res_if.source o_res
);
    localparam int CNTW = $clog2(MAX_TOKENS_HELD + 1);
    localparam int AW   = (MAX_TOKENS_HELD > 1) ? $clog2(MAX_TOKENS_HELD) : 1;

    // ------------------------------------------------------------------
    // Configuration: keep the minimum segment length squared so stage one
    // only compares
    // ------------------------------------------------------------------
    logic [sdt_pkg::MIN_SQ_W-1:0] r_min_sq;
    logic [sdt_pkg::MIN_SQ_W-1:0] cfg_sq;

    assign i_cfg.ready = i_rst_n;
    assign cfg_sq = sdt_pkg::MIN_SQ_W'(i_cfg.min_len) *
                    sdt_pkg::MIN_SQ_W'(i_cfg.min_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sq <= sdt_pkg::MIN_SQ_W'(sdt_pkg::MIN_SEG_RESET) *
                        sdt_pkg::MIN_SQ_W'(sdt_pkg::MIN_SEG_RESET);
        end else if (i_cfg.valid) begin
            r_min_sq <= cfg_sq;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow: each stage advances when the one after it is free
    // ------------------------------------------------------------------
    logic r_v1;
    logic r_v2;
    logic r_out_valid;
    logic out_free;
    logic s2_free;
    logic s1_free;
    logic acc_in;
    logic adv_b;
    logic adv_c;

    assign out_free    = !r_out_valid || o_res.ready;
    assign adv_c       = r_v2 && out_free;
    assign s2_free     = !r_v2 || out_free;
    assign adv_b       = r_v1 && s2_free;
    assign s1_free     = !r_v1 || s2_free;
    assign i_cmd.ready = s1_free && i_rst_n;
    assign acc_in      = i_cmd.valid && s1_free && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_v1 <= i_cmd.valid;
            end
            if (s2_free) begin
                r_v2 <= r_v1;
            end
            if (out_free) begin
                r_out_valid <= r_v2;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage one: anchor and segment length
    // ------------------------------------------------------------------
    logic [COORD_WIDTH-1:0] seg_abs_x;
    logic [COORD_WIDTH-1:0] seg_abs_y;
    sdt_pkg::t_ctl          seg_ctl;
    logic [7:0]             r_idx1;
    logic [7:0]             r_idx2;

    sdt_seg #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_seg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (acc_in),
        .i_op      (sdt_pkg::t_op'(i_cmd.opcode)),
        .i_point_x (i_cmd.point_x),
        .i_point_y (i_cmd.point_y),
        .i_min_sq  (r_min_sq),
        .o_abs_x   (seg_abs_x),
        .o_abs_y   (seg_abs_y),
        .o_ctl     (seg_ctl)
    );

    // carry the read index alongside the pipeline
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_idx1 <= i_cmd.read_index;
        end
        if (adv_b) begin
            r_idx2 <= r_idx1;
        end
    end

    // ------------------------------------------------------------------
    // Stage two: slope products; the token RAM read issues here
    // ------------------------------------------------------------------
    sdt_pkg::t_ctl dir_ctl;
    sdt_pkg::t_dir c_dir;

    sdt_dir #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dir (
        .i_clk   (i_clk),
        .i_load  (adv_b),
        .i_abs_x (seg_abs_x),
        .i_abs_y (seg_abs_y),
        .i_ctl   (seg_ctl),
        .o_ctl   (dir_ctl),
        .o_dir   (c_dir)
    );

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [sdt_pkg::TOKEN_W-1:0] ram_rdata;
    logic                       r_fwd_hit;
    logic [sdt_pkg::TOKEN_W-1:0] r_fwd_data;

    sdt_ram #(
        .WIDTH (sdt_pkg::TOKEN_W),
        .DEPTH (MAX_TOKENS_HELD),
        .AW    (AW)
    ) u_token_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (c_dir),
        .i_re    (adv_b),
        .i_raddr (r_idx1[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // the RAM returns old data on a same-entry write: forward the new token
    always_ff @(posedge i_clk) begin
        if (adv_b) begin
            r_fwd_hit  <= ram_we && (ram_waddr == r_idx1[AW-1:0]);
            r_fwd_data <= c_dir;
        end
    end

    // ------------------------------------------------------------------
    // Stage three: append, clear and read against the held count
    // ------------------------------------------------------------------
    logic [CNTW-1:0]              r_count;
    logic [CNTW-1:0]              n_count;
    sdt_pkg::t_dir                r_last;
    logic                         c_repeat;
    logic                         c_full;
    logic                         c_append;
    logic [sdt_pkg::TOKEN_W-1:0]  c_tok;
    logic [sdt_pkg::READ_W-1:0]   c_read;

    always_comb begin
        c_repeat = (r_count != '0) && (r_last == c_dir);
        c_full   = (r_count == CNTW'(MAX_TOKENS_HELD));
        c_append = (dir_ctl.op == sdt_pkg::OP_ADD_POINT) && dir_ctl.moved &&
                   !c_repeat && !c_full;

        priority if (c_append) begin
            n_count = r_count + CNTW'(1);
        end else if (dir_ctl.op == sdt_pkg::OP_CLEAR) begin
            n_count = '0;
        end else begin
            n_count = r_count;
        end

        // reads at or beyond the count return the empty marker
        c_tok = r_fwd_hit ? r_fwd_data : ram_rdata;
        if ((dir_ctl.op == sdt_pkg::OP_READ_TOKEN) &&
            ({1'b0, r_idx2} < (sdt_pkg::INDEX_W + 1)'(r_count))) begin
            c_read = sdt_pkg::READ_W'(c_tok);
        end else begin
            c_read = sdt_pkg::NO_TOKEN;
        end
    end

    assign ram_we    = adv_c && c_append;
    assign ram_waddr = r_count[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (adv_c) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_last <= c_dir;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                             r_out_appended;
    logic [sdt_pkg::TOKEN_W-1:0]      r_out_dir;
    logic [sdt_pkg::COUNT_OUT_W-1:0]  r_out_count;
    logic [sdt_pkg::READ_W-1:0]       r_out_read;

    always_ff @(posedge i_clk) begin
        if (adv_c) begin
            r_out_appended <= c_append;
            r_out_dir      <= c_append ? c_dir : sdt_pkg::DIR_R;
            r_out_count    <= sdt_pkg::COUNT_OUT_W'(n_count);
            r_out_read     <= c_read;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.appended      = r_out_appended;
    assign o_res.new_direction = r_out_dir;
    assign o_res.token_count   = r_out_count;
    assign o_res.read_value    = r_out_read;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_TOKENS_HELD))
        else $error("token count beyond store depth");

    a_append_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_count == $past(r_count) + CNTW'(1)) && (r_last == $past(c_dir)))
        else $error("append did not advance count and last token together");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv_c && (dir_ctl.op == sdt_pkg::OP_CLEAR)) |=> (r_count == '0))
        else $error("clear left tokens held");

endmodule

FILE: tb/tb_stroke_direction_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stroke_direction_tokenizer: self-checking bench for the gesture tokenizer
// Feeds command beats (points, clears, token reads) and predicts every result
// beat from a behavioral copy of the anchor, token store and segment length.
// It compares each result in order and walks the minimum segment length
// through its extremes.
// ----------------------------------------------------------------------------
module tb_stroke_direction_tokenizer;

    localparam int TOKENS_MAX  = 64;
    localparam int STALL_LIMIT = 2000;   // cycles without any beat before giving up

    typedef struct {
        sdt_pkg::t_op       op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [7:0]         idx;
    } t_cmd_item;

    typedef struct {
        logic          appended;
        sdt_pkg::t_dir dir;
        logic [6:0]    count;
        logic [7:0]    rdval;
    } t_token_result;

    logic i_clk;
    logic i_rst_n;

    sdt_cmd_if #(.COORD_WIDTH(16)) cmd_bus ();
    sdt_cfg_if                     cfg_bus ();
    sdt_res_if                     res_bus ();

    stroke_direction_tokenizer #(
        .MAX_TOKENS_HELD (TOKENS_MAX),
        .COORD_WIDTH     (16)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    // Behavioral copy of the tokenizer state.
    logic signed [15:0] anchor_x;
    logic signed [15:0] anchor_y;
    bit                 anchor_set;
    int                 held;
    sdt_pkg::t_dir      token_mem [TOKENS_MAX];
    logic [11:0]        seg_model;

    t_cmd_item     pending_cmds [$];
    t_token_result results_due  [$];

    // Handshake bookkeeping shared between the clock edges.
    bit cmd_took;
    bit gaps_allowed;
    int cmd_gap;
    int res_gap;
    int quiet_left;
    int stall_cycles;

    // Run statistics.
    int n_errors;
    int n_sent;
    int n_results;
    int n_appended;
    int n_full_drops;
    int n_short;
    int n_read_hits;
    int n_settings;

    always #10 i_clk = ~i_clk;

    // Map a displacement onto one of the eight sectors; a tie on the 22.5 deg
    // bound goes to the diagonal, and no displacement at all counts as right.
    function automatic sdt_pkg::t_dir sector_of(input longint dx, input longint dy);
        longint ax;
        longint ay;
        longint slope;
        ax    = (dx < 0) ? -dx : dx;
        ay    = (dy < 0) ? -dy : dy;
        slope = longint'(sdt_pkg::TAN_SECTOR_Q16);
        if (ax == 0 && ay == 0)
            return sdt_pkg::DIR_R;
        if ((ay <<< sdt_pkg::Q_SHIFT) < slope * ax)
            return (dx > 0) ? sdt_pkg::DIR_R : sdt_pkg::DIR_L;
        if ((ax <<< sdt_pkg::Q_SHIFT) < slope * ay)
            return (dy < 0) ? sdt_pkg::DIR_U : sdt_pkg::DIR_D;
        if (dx > 0)
            return (dy < 0) ? sdt_pkg::DIR_UR : sdt_pkg::DIR_DR;
        return (dy < 0) ? sdt_pkg::DIR_UL : sdt_pkg::DIR_DL;
    endfunction

    // Advance the behavioral state by one command and produce its result.
    task automatic tokenize_cmd(input t_cmd_item c, output t_token_result r);
        longint        dx;
        longint        dy;
        longint        reach;
        sdt_pkg::t_dir d;
        r.appended = 1'b0;
        r.dir      = sdt_pkg::DIR_R;
        r.rdval    = sdt_pkg::NO_TOKEN;
        case (c.op)
            sdt_pkg::OP_ADD_POINT: begin
                if (!anchor_set) begin
                    anchor_x   = c.x;
                    anchor_y   = c.y;
                    anchor_set = 1'b1;
                end else begin
                    dx    = longint'(c.x) - longint'(anchor_x);
                    dy    = longint'(c.y) - longint'(anchor_y);
                    reach = longint'(seg_model) * longint'(seg_model);
                    if (dx * dx + dy * dy < reach) begin
                        n_short++;
                    end else begin
                        d        = sector_of(dx, dy);
                        anchor_x = c.x;
                        anchor_y = c.y;
                        if (held > 0 && token_mem[held-1] == d) begin
                            // repeated direction: anchor moved, nothing appended
                        end else if (held >= TOKENS_MAX) begin
                            n_full_drops++;
                        end else begin
                            token_mem[held] = d;
                            held++;
                            r.appended = 1'b1;
                            r.dir      = d;
                            n_appended++;
                        end
                    end
                end
            end
            sdt_pkg::OP_CLEAR: begin
                held       = 0;
                anchor_set = 1'b0;
            end
            sdt_pkg::OP_READ_TOKEN: begin
                if (c.idx < held) begin
                    r.rdval = {5'd0, token_mem[c.idx]};
                    n_read_hits++;
                end
            end
            default: ;
        endcase
        r.count = held[6:0];
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("%0t ns: mismatch on %s, got %0d, want %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Rising edge: check result beats, predict accepted commands, track the
    // register, and watch for a stalled pipe.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_token_result want;
        t_token_result got;
        t_cmd_item     c;
        bit            moved;
        moved = 1'b0;
        if (i_rst_n) begin
            // Check the result first: a beat leaving now belongs to an older command.
            if (res_bus.valid && res_bus.ready) begin
                moved = 1'b1;
                n_results++;
                if (results_due.size() == 0) begin
                    report_mismatch("result beat with nothing pending", 1, 0);
                end else begin
                    want = results_due.pop_front();
                    if (res_bus.appended !== want.appended)
                        report_mismatch("appended", res_bus.appended, want.appended);
                    if (res_bus.new_direction !== want.dir)
                        report_mismatch("new_direction", res_bus.new_direction, want.dir);
                    if (res_bus.token_count !== want.count)
                        report_mismatch("token_count", res_bus.token_count, want.count);
                    if (res_bus.read_value !== want.rdval)
                        report_mismatch("read_value", res_bus.read_value, want.rdval);
                end
            end
            if (cmd_bus.valid && cmd_bus.ready) begin
                moved = 1'b1;
                c.op  = sdt_pkg::t_op'(cmd_bus.opcode);
                c.x   = cmd_bus.point_x;
                c.y   = cmd_bus.point_y;
                c.idx = cmd_bus.read_index;
                tokenize_cmd(c, got);
                results_due.push_back(got);
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                moved     = 1'b1;
                seg_model = cfg_bus.min_len;
                n_settings++;
            end
        end
        cmd_took = cmd_bus.valid && cmd_bus.ready && i_rst_n;
        if (!i_rst_n || moved)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results still due",
                     stall_cycles, results_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Falling edge: drive command beats from the pending queue and toggle
    // result ready. Both sides drop into idle bursts, except during quiet
    // stretches and once gaps are switched off for the last phase.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive
        t_cmd_item c;
        if (quiet_left > 0)
            quiet_left--;
        else if ($urandom_range(0, 63) == 0)
            quiet_left = $urandom_range(20, 60);

        // Only move on once the current beat has been taken.
        if (!cmd_bus.valid || cmd_took) begin
            if (cmd_gap > 0) begin
                cmd_gap--;
                cmd_bus.valid <= 1'b0;
            end else if (gaps_allowed && quiet_left == 0 && $urandom_range(0, 5) == 0) begin
                cmd_gap = $urandom_range(0, 10);
                cmd_bus.valid <= 1'b0;
            end else if (i_rst_n && pending_cmds.size() != 0) begin
                c = pending_cmds.pop_front();
                cmd_bus.opcode     <= c.op;
                cmd_bus.point_x    <= c.x;
                cmd_bus.point_y    <= c.y;
                cmd_bus.read_index <= c.idx;
                cmd_bus.valid      <= 1'b1;
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end

        // Stall the result side in bursts too.
        if (res_gap > 0) begin
            res_gap--;
            res_bus.ready <= 1'b0;
        end else if (gaps_allowed && quiet_left == 0 && $urandom_range(0, 5) == 0) begin
            res_gap = $urandom_range(0, 10);
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_cmd(input sdt_pkg::t_op op, input int x, input int y,
                             input int idx);
        t_cmd_item c;
        c.op  = op;
        c.x   = 16'(x);
        c.y   = 16'(y);
        c.idx = 8'(idx);
        pending_cmds.push_back(c);
        n_sent++;
    endtask

    task automatic queue_point(input int x, input int y);
        queue_cmd(sdt_pkg::OP_ADD_POINT, x, y, $urandom_range(0, 255));
    endtask

    task automatic queue_read(input int idx);
        queue_cmd(sdt_pkg::OP_READ_TOKEN, $urandom_range(0, 65535),
                  $urandom_range(0, 65535), idx);
    endtask

    // Noise beat: any opcode with every field random.
    task automatic queue_noise;
        sdt_pkg::t_op op;
        case ($urandom_range(0, 2))
            0:       op = sdt_pkg::OP_ADD_POINT;
            1:       op = sdt_pkg::OP_CLEAR;
            default: op = sdt_pkg::OP_READ_TOKEN;
        endcase
        queue_cmd(op, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 255));
    endtask

    // One stroke: usually a clear, an anchor, then steps of about twice the
    // segment length in random directions (some fall short and get dropped),
    // with token reads, sector-bound ties and the odd clear mixed in.
    task automatic queue_gesture(input int n_steps, input int seg);
        int px;
        int py;
        int dx;
        int dy;
        int reach;
        int k;
        reach = 2 * seg + 16;
        if ($urandom_range(0, 4) != 0)
            queue_cmd(sdt_pkg::OP_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 255));
        px = $urandom_range(0, 65535) - 32768;
        py = $urandom_range(0, 65535) - 32768;
        queue_point(px, py);
        for (k = 0; k < n_steps; k++) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    queue_read($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 70));
                end
                2: begin
                    // land exactly on the 22.5 deg bound, horizontal or vertical
                    dx = (px < 0) ? 32768 : -32768;
                    dy = (py < 0) ? 13573 : -13573;
                    if ($urandom_range(0, 1) == 0) begin
                        dx = (px < 0) ? 13573 : -13573;
                        dy = (py < 0) ? 32768 : -32768;
                    end
                    px = px + dx;
                    py = py + dy;
                    queue_point(px, py);
                end
                3: begin
                    if ($urandom_range(0, 2) == 0)
                        queue_cmd(sdt_pkg::OP_CLEAR, px, py, 0);
                    else
                        queue_point(px, py);
                end
                default: begin
                    dx = $urandom_range(0, 2 * reach) - reach;
                    dy = $urandom_range(0, 2 * reach) - reach;
                    if (px + dx > 32767 || px + dx < -32768) dx = -dx;
                    if (py + dy > 32767 || py + dy < -32768) dy = -dy;
                    px = px + dx;
                    py = py + dy;
                    queue_point(px, py);
                end
            endcase
        end
    endtask

    // Hold until no command is waiting, in flight or owed a result.
    task automatic wait_drained;
        while (pending_cmds.size() != 0 || cmd_bus.valid || results_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_min_len(input logic [11:0] value);
        wait_drained();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.min_len <= value;
        cfg_bus.valid   <= 1'b1;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Random traffic for one register setting; long strokes fill the store.
    task automatic run_phase(input int n_items, input int seg);
        int stop_at;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0)
                queue_noise();
            else if ($urandom_range(0, 5) == 0)
                queue_gesture($urandom_range(70, 100), seg);
            else
                queue_gesture($urandom_range(3, 30), seg);
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int seg;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.opcode     = sdt_pkg::OP_ADD_POINT;
        cmd_bus.point_x    = '0;
        cmd_bus.point_y    = '0;
        cmd_bus.read_index = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.min_len    = '0;
        res_bus.ready      = 1'b0;
        anchor_x           = '0;
        anchor_y           = '0;
        anchor_set         = 1'b0;
        held               = 0;
        seg_model          = sdt_pkg::MIN_SEG_RESET;
        gaps_allowed       = 1'b1;
        cmd_took           = 1'b0;
        cmd_gap            = 0;
        res_gap            = 0;
        quiet_left         = 0;
        stall_cycles       = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed stroke at the reset segment length: every direction once,
        // a short step, a repeat, a tie on the bound and the coordinate rails.
        queue_read(0);
        queue_point(0, 0);
        queue_point(10, 0);
        queue_point(100, 0);
        queue_point(200, 0);
        queue_point(300, -100);
        queue_point(300, -200);
        queue_point(200, -300);
        queue_point(100, -300);
        queue_point(0, -200);
        queue_point(0, -100);
        queue_point(100, 0);
        queue_point(-32768, 0);
        queue_point(0, 13573);
        queue_point(32767, 32767);
        queue_point(-32768, -32768);
        queue_point(32767, -32768);
        queue_read(0);
        queue_read(11);
        queue_read(12);
        queue_read(64);
        queue_read(255);
        queue_cmd(sdt_pkg::OP_CLEAR, -1, -1, 255);
        queue_read(0);
        run_phase(250, sdt_pkg::MIN_SEG_RESET);

        // Zero segment length: a point on the anchor itself counts as right.
        write_min_len(12'd0);
        queue_cmd(sdt_pkg::OP_CLEAR, 0, 0, 0);
        queue_point(5, 5);
        queue_point(5, 5);
        queue_point(5, 5);
        queue_read(0);
        run_phase(200, 0);

        write_min_len(12'd4095);
        run_phase(200, 4095);

        write_min_len(12'd1);
        run_phase(200, 1);

        seg = $urandom_range(2, 4094);
        write_min_len(12'(seg));
        run_phase(200, seg);

        // Last stretch runs back to back with no idling on either side.
        seg = $urandom_range(2, 200);
        write_min_len(12'(seg));
        gaps_allowed = 1'b0;
        run_phase(250, seg);

        repeat (10) @(posedge i_clk);
        $display("covered %0d commands and %0d results: %0d tokens appended, %0d %s",
                 n_sent, n_results, n_appended, n_full_drops, "refused by a full store");
        $display("%0d segment length writes, %0d short steps dropped, %0d reads inside the count",
                 n_settings, n_short, n_read_hits);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
